// File: design/pft_pkg.sv
// Package for the prime filter: default sizes and shared constants.
// No dependencies; imported by the top level, both checkers and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package pft_pkg;

    // Default parameter values
    localparam int unsigned VALUE_WIDTH_DEF = 16;
    localparam int unsigned DEST_DEPTH_DEF  = 256;

    // Width of the slot field on the result port
    localparam int unsigned SLOT_W = 8;

    // Trial division starts here; values below it are not prime
    localparam int unsigned FIRST_DIVISOR = 2;

endpackage : pft_pkg

`default_nettype wire

// File: design/pft_rem_unit.sv
// Shared remainder unit: restoring bit-serial divider, one dividend bit per cycle.
// Standalone; instantiated by prime_filter_trial_division.
`timescale 1ns / 1ps
`default_nettype none

module pft_rem_unit #(
    parameter int unsigned W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      remainder
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, dvd_reg[W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule : pft_rem_unit

`default_nettype wire

// File: design/prime_filter_trial_division.sv
// Channel | ports                                   | direction
// s_      | s_valid s_ready s_value s_last_in_array  | item in
// m_      | m_valid m_ready m_keep m_prime_value     | result out
//         | m_slot m_overflow m_end_of_array         |
//
// One item at a time. An item tries divisors 2, 3, ... while d*d <= value,
// stopping early when a divisor is found; each divisor takes one pass of the
// bit-serial remainder unit. Values below 2 go straight to the result.
// Reset is synchronous, active low, and clears the prime count.
// A stalled result is held in the output register while the next item runs.
//
// Top level of the trial-division prime filter; uses pft_pkg and pft_rem_unit.
`timescale 1ns / 1ps
`default_nettype none

module prime_filter_trial_division
    import pft_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned DEST_DEPTH  = DEST_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    input  wire logic                   s_last_in_array,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_keep,
    output logic [VALUE_WIDTH-1:0]      m_prime_value,
    output logic [SLOT_W-1:0]           m_slot,
    output logic                        m_overflow,
    output logic                        m_end_of_array
);

    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned CNT_W = $clog2(DEST_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [W-1:0]   v_reg, v_next;
    logic           last_reg, last_next;
    logic [W-1:0]   d_reg, d_next;
    logic [W:0]     dsq_reg, dsq_next;
    logic           prime_reg, prime_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic           m_valid_reg, m_valid_next;
    logic           keep_reg, keep_next;
    logic [W-1:0]   val_out_reg, val_out_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic           ovf_reg, ovf_next;
    logic           eoa_reg, eoa_next;

    logic           div_start;
    logic           div_done;
    logic [W-1:0]   div_rem;
    logic           full;
    logic [CNT_W-1:0] slot_wide;
    logic           in_accept;

    pft_rem_unit #(.W(W)) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (v_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign in_accept = s_valid && s_ready;
    assign full      = (count_reg >= CNT_W'(DEST_DEPTH));
    assign slot_wide = full ? CNT_W'(DEST_DEPTH - 1) : count_reg;

    // Sequencer: walk divisors while d*d <= value, one remainder per divisor
    always_comb begin
        state_next   = state_reg;
        v_next       = v_reg;
        last_next    = last_reg;
        d_next       = d_reg;
        dsq_next     = dsq_reg;
        prime_next   = prime_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        keep_next    = keep_reg;
        val_out_next = val_out_reg;
        slot_next    = slot_reg;
        ovf_next     = ovf_reg;
        eoa_next     = eoa_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    v_next    = s_value;
                    last_next = s_last_in_array;
                    d_next    = W'(FIRST_DIVISOR);
                    dsq_next  = (W + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
                    if (s_value < W'(FIRST_DIVISOR)) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (dsq_reg > {1'b0, v_reg}) begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + 1'b1;
                        dsq_next   = dsq_reg + {d_reg, 1'b1};
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    keep_next    = prime_reg && !full;
                    ovf_next     = prime_reg && full;
                    val_out_next = v_reg;
                    slot_next    = SLOT_W'(slot_wide);
                    eoa_next     = last_reg;
                    if (last_reg) begin
                        count_next = '0;
                    end else if (prime_reg && !full) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        v_reg       <= v_next;
        last_reg    <= last_next;
        d_reg       <= d_next;
        dsq_reg     <= dsq_next;
        prime_reg   <= prime_next;
        keep_reg    <= keep_next;
        val_out_reg <= val_out_next;
        slot_reg    <= slot_next;
        ovf_reg     <= ovf_next;
        eoa_reg     <= eoa_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_keep         = keep_reg;
    assign m_prime_value  = val_out_reg;
    assign m_slot         = slot_reg;
    assign m_overflow     = ovf_reg;
    assign m_end_of_array = eoa_reg;

endmodule : prime_filter_trial_division

`default_nettype wire

// File: design/pft_checker.sv
// Port-level checks for the prime filter, bound to the top level.
// Depends on pft_pkg and prime_filter_trial_division.
`timescale 1ns / 1ps
`default_nettype none

module pft_checker
    import pft_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic                   m_keep,
    input wire logic [VALUE_WIDTH-1:0] m_prime_value,
    input wire logic                   m_overflow
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_value) && $stable(m_keep))
        else $error("result changed while stalled");

    // Kept and overflow never together
    a_keep_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_keep && m_overflow))
        else $error("keep and overflow both set");

    // Zero and one are never kept
    a_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_prime_value < VALUE_WIDTH'(FIRST_DIVISOR)) |-> !m_keep && !m_overflow)
        else $error("value below two reported prime");

    // One item at a time: busy right after accepting
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting an item");

endmodule : pft_checker

bind prime_filter_trial_division pft_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pft_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_keep        (m_keep),
    .m_prime_value (m_prime_value),
    .m_overflow    (m_overflow)
);

`default_nettype wire

// File: verif/prime_filter_checker.sv
`timescale 1ns / 1ps
// Checker for the prime filter: watches both channels, predicts each result
// with its own trial-division model and compares in order. Uses pft_pkg.

module prime_filter_checker
    import pft_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [VALUE_WIDTH_DEF-1:0] s_value,
    input  logic                       s_last_in_array,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_keep,
    input  logic [VALUE_WIDTH_DEF-1:0] m_prime_value,
    input  logic [SLOT_W-1:0]          m_slot,
    input  logic                       m_overflow,
    input  logic                       m_end_of_array,
    output int                         fail_count,
    output int                         outstanding,
    output int                         n_checked,
    output int                         n_kept,
    output int                         n_overflow,
    output int                         n_arrays
);

    typedef struct packed {
        logic                       keep;
        logic [VALUE_WIDTH_DEF-1:0] value;
        logic [SLOT_W-1:0]          slot;
        logic                       overflow;
        logic                       end_of_array;
    } filter_result_t;

    filter_result_t expected_results[$];
    logic [9:0]     primes_in_array;
    int             errs;
    int             checked;
    int             kept;
    int             ovf;
    int             arrays;

    // Trial division up to the square root; values below the first divisor fail
    function automatic bit value_is_prime(input logic [VALUE_WIDTH_DEF-1:0] v);
        int unsigned n;
        int unsigned d;
        n = 32'(v);
        if (n < FIRST_DIVISOR)
            return 1'b0;
        for (d = FIRST_DIVISOR; d * d <= n; d++) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Expected result for one item; advances the running prime count
    function automatic filter_result_t predict_filter(
        input logic [VALUE_WIDTH_DEF-1:0] v,
        input logic                       last,
        ref   logic [9:0]                 count
    );
        filter_result_t r;
        bit             prime;
        bit             full;
        int unsigned    slot_idx;
        prime    = value_is_prime(v);
        full     = (32'(count) >= DEST_DEPTH_DEF);
        slot_idx = full ? DEST_DEPTH_DEF - 1 : 32'(count);
        r.keep         = prime && !full;
        r.value        = v;
        r.slot         = slot_idx[SLOT_W-1:0];
        r.overflow     = prime && full;
        r.end_of_array = last;
        if (r.keep)
            count = count + 10'd1;
        if (last)
            count = '0;
        return r;
    endfunction

    function automatic void report_field(input string name, input longint exp_v,
                                         input longint act_v);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                 act_v);
    endfunction

    // Compare outgoing items, then record incoming ones
    always @(posedge aclk) begin
        filter_result_t exp_r;
        if (!aresetn) begin
            expected_results.delete();
            primes_in_array = '0;
            errs     = 0;
            checked  = 0;
            kept     = 0;
            ovf      = 0;
            arrays   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with no item pending, value %0d", $time,
                             m_prime_value);
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (m_keep !== exp_r.keep) begin
                        report_field("keep", exp_r.keep, m_keep);
                        errs++;
                    end
                    if (m_prime_value !== exp_r.value) begin
                        report_field("prime_value", exp_r.value, m_prime_value);
                        errs++;
                    end
                    if (m_slot !== exp_r.slot) begin
                        report_field("slot", exp_r.slot, m_slot);
                        errs++;
                    end
                    if (m_overflow !== exp_r.overflow) begin
                        report_field("overflow", exp_r.overflow, m_overflow);
                        errs++;
                    end
                    if (m_end_of_array !== exp_r.end_of_array) begin
                        report_field("end_of_array", exp_r.end_of_array, m_end_of_array);
                        errs++;
                    end
                    kept   += int'(exp_r.keep);
                    ovf    += int'(exp_r.overflow);
                    arrays += int'(exp_r.end_of_array);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(
                    predict_filter(s_value, s_last_in_array, primes_in_array));
        end
        fail_count  <= errs;
        outstanding <= expected_results.size();
        n_checked   <= checked;
        n_kept      <= kept;
        n_overflow  <= ovf;
        n_arrays    <= arrays;
    end

endmodule : prime_filter_checker

// File: verif/prime_filter_trial_division_test.sv
`timescale 1ns / 1ps
// Top of the prime filter testbench: clock, reset, item stimulus, result
// back-pressure, watchdog and verdict. Uses pft_pkg and prime_filter_checker.

module prime_filter_trial_division_test;
    import pft_pkg::*;

    localparam int STALL_LIMIT = 50000;
    localparam int RANDOM_ITEMS = 115;
    localparam int unsigned SMALL_PRIMES[8] = '{2, 3, 5, 7, 11, 13, 251, 257};
    localparam int unsigned EDGE_VALUES[9] =
        '{0, 1, 2, 65535, 65521, 65534, 32768, 32767, 65025};

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic [VALUE_WIDTH_DEF-1:0] s_value         = '0;
    logic                       s_last_in_array = 1'b0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic                       m_keep;
    logic [VALUE_WIDTH_DEF-1:0] m_prime_value;
    logic [SLOT_W-1:0]          m_slot;
    logic                       m_overflow;
    logic                       m_end_of_array;

    int fail_count;
    int outstanding;
    int n_checked;
    int n_kept;
    int n_overflow;
    int n_arrays;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit steady      = 1'b0;

    always #5 aclk = ~aclk;

    prime_filter_trial_division u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_last_in_array (s_last_in_array),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_keep          (m_keep),
        .m_prime_value   (m_prime_value),
        .m_slot          (m_slot),
        .m_overflow      (m_overflow),
        .m_end_of_array  (m_end_of_array)
    );

    prime_filter_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_last_in_array (s_last_in_array),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_keep          (m_keep),
        .m_prime_value   (m_prime_value),
        .m_slot          (m_slot),
        .m_overflow      (m_overflow),
        .m_end_of_array  (m_end_of_array),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .n_checked       (n_checked),
        .n_kept          (n_kept),
        .n_overflow      (n_overflow),
        .n_arrays        (n_arrays)
    );

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mix of full-range, small, prime and corner values
    function automatic logic [VALUE_WIDTH_DEF-1:0] draw_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return VALUE_WIDTH_DEF'($urandom_range(0, 65535));
        else if (r < 65)
            return VALUE_WIDTH_DEF'($urandom_range(0, 300));
        else if (r < 85)
            return VALUE_WIDTH_DEF'(SMALL_PRIMES[$urandom_range(0, 7)]);
        return VALUE_WIDTH_DEF'(EDGE_VALUES[$urandom_range(0, 8)]);
    endfunction

    // Present one item and hold it until accepted
    task automatic send_item(input logic [VALUE_WIDTH_DEF-1:0] v, input logic last);
        int gap;
        gap = steady ? 0 : draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_value         <= v;
        s_last_in_array <= last;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
    endtask

    // Result back-pressure
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            m_ready   <= 1'b0;
            hold_left <= draw_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: stretches with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int i;
        int len;
        int sent;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero and one, smallest primes, squares, corner values
        send_item(16'd0, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd2, 1'b0);
        send_item(16'd3, 1'b0);
        send_item(16'd4, 1'b0);
        send_item(16'd9, 1'b0);
        send_item(16'd25, 1'b0);
        send_item(16'd49, 1'b0);
        send_item(16'd121, 1'b0);
        send_item(16'd65535, 1'b0);
        send_item(16'd65521, 1'b0);
        send_item(16'd65534, 1'b0);
        send_item(16'd32768, 1'b0);
        send_item(16'd32749, 1'b0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        send_item(16'd65025, 1'b1);
        // end of array on a prime, then arrays of one item
        send_item(16'd7, 1'b0);
        send_item(16'd13, 1'b1);
        send_item(16'd0, 1'b1);
        send_item(16'd17, 1'b1);
        send_item(16'd19, 1'b0);

        // Random arrays of random length, some with no idling at all
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len    = $urandom_range(1, 20);
            steady = ($urandom_range(0, 4) == 0);
            for (i = 0; i < len; i++) begin
                send_item(draw_value(), i == len - 1);
                sent++;
            end
        end
        s_valid <= 1'b0;
        steady  = 1'b0;

        // Let the pending count catch up with the last accepted item, then let it drain
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Checked %0d results over %0d arrays: %0d primes kept, %0d overflowed.",
                 n_checked, n_arrays, n_kept, n_overflow);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : prime_filter_trial_division_test
